@@ design/sha1_pkg.sv @@
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types and constants for the SHA-1 hash block.
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_GRP0 = 32'h5A827999;
  localparam logic [31:0] K_GRP1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_GRP2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_GRP3 = 32'hCA62C1D6;

  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [2:0] LAST_WORD  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    SEL_IN,
    SEL_PAD,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  typedef enum logic [1:0] {
    GRP_CH,
    GRP_PAR1,
    GRP_MAJ,
    GRP_PAR2
  } round_grp_t;

  typedef struct packed {
    logic       push;       // shift one byte into the block buffer
    byte_sel_t  byte_sel;
    logic [2:0] len_idx;    // byte of the length field, 0 = most significant
    logic       count_len;  // add 8 to the bit count
    logic       load;       // working vars <= chain words
    logic       round;      // one compression round
    round_grp_t grp;
    logic       add;        // chain words += working vars
    logic       rearm;      // back to initial chain and zero length
    logic [2:0] widx;       // digest word on the output
  } dp_cmd_t;

endpackage

@@ design/sha1_dp.sv @@
// ----------------------------------------------------------------------------
// sha1_dp
// Datapath: byte buffer / schedule shift line, round logic, chain words.
// ----------------------------------------------------------------------------
module sha1_dp
  import sha1_pkg::*;
#(
  parameter int LENGTH_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  input  logic [7:0]  in_byte,
  output logic [31:0] digest_word
);

  // Block buffer doubles as the schedule window: byte 0 lands in the top
  // bits, and during rounds the window shifts up a word per round.
  logic [511:0] buf_r, buf_nxt;
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;
  logic [31:0]  h_r [5];
  logic [LENGTH_BITS-1:0] len_r;

  logic [63:0] len64;
  logic [7:0]  byte_in;
  logic [31:0] w0, w2, w8, w13, wx, wnew;
  logic [31:0] f, k, t;

  assign len64 = 64'(len_r);

  always_comb begin
    unique case (cmd.byte_sel)
      SEL_IN:   byte_in = in_byte;
      SEL_PAD:  byte_in = PAD_BYTE;
      SEL_ZERO: byte_in = 8'h00;
      SEL_LEN:  byte_in = len64[{~cmd.len_idx, 3'b000} +: 8];
      default:  byte_in = 8'h00;
    endcase
  end

  assign w0   = buf_r[511:480];
  assign w2   = buf_r[447:416];
  assign w8   = buf_r[255:224];
  assign w13  = buf_r[95:64];
  assign wx   = w13 ^ w8 ^ w2 ^ w0;
  assign wnew = {wx[30:0], wx[31]};

  always_comb begin
    unique case (cmd.grp)
      GRP_CH: begin
        f = (b_r & c_r) | (~b_r & d_r);
        k = K_GRP0;
      end
      GRP_PAR1: begin
        f = b_r ^ c_r ^ d_r;
        k = K_GRP1;
      end
      GRP_MAJ: begin
        f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
        k = K_GRP2;
      end
      GRP_PAR2: begin
        f = b_r ^ c_r ^ d_r;
        k = K_GRP3;
      end
      default: begin
        f = 32'h0;
        k = 32'h0;
      end
    endcase
  end

  assign t = {a_r[26:0], a_r[31:27]} + f + e_r + w0 + k;

  always_comb begin
    buf_nxt = buf_r;
    if (cmd.push) begin
      buf_nxt = {buf_r[503:0], byte_in};
    end else if (cmd.round) begin
      buf_nxt = {buf_r[479:0], wnew};
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    if (cmd.load) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (cmd.round) begin
      a_r <= t;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.rearm) begin
      for (int i = 0; i < 5; i++) h_r[i] <= H_INIT[i];
      len_r <= '0;
    end else begin
      if (cmd.add) begin
        h_r[0] <= h_r[0] + a_r;
        h_r[1] <= h_r[1] + b_r;
        h_r[2] <= h_r[2] + c_r;
        h_r[3] <= h_r[3] + d_r;
        h_r[4] <= h_r[4] + e_r;
      end
      if (cmd.count_len) len_r <= len_r + LENGTH_BITS'(8);
    end
  end

  always_comb begin
    unique case (cmd.widx)
      3'd0:    digest_word = h_r[0];
      3'd1:    digest_word = h_r[1];
      3'd2:    digest_word = h_r[2];
      3'd3:    digest_word = h_r[3];
      default: digest_word = h_r[4];
    endcase
  end

endmodule

@@ design/sha1_ctrl.sv @@
// ----------------------------------------------------------------------------
// sha1_ctrl
// Controller: byte fill, padding sequence, round count, digest readout.
// ----------------------------------------------------------------------------
module sha1_ctrl
  import sha1_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  logic    in_has_byte,
  input  logic    in_end,
  output logic    out_tvalid,
  input  logic    out_tready,
  output logic    out_last,
  output dp_cmd_t cmd
);

  state_t     state_r, state_nxt;
  logic [5:0] fill_r, fill_nxt;
  logic [6:0] round_r, round_nxt;
  logic [2:0] widx_r, widx_nxt;
  logic       fin_r, fin_nxt;         // padding phase of a message
  logic       pad_first_r, pad_first_nxt;
  logic       len_ok_r, len_ok_nxt;   // length field goes in this block

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      round_r     <= '0;
      widx_r      <= '0;
      fin_r       <= 1'b0;
      pad_first_r <= 1'b0;
      len_ok_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      round_r     <= round_nxt;
      widx_r      <= widx_nxt;
      fin_r       <= fin_nxt;
      pad_first_r <= pad_first_nxt;
      len_ok_r    <= len_ok_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    round_nxt     = round_r;
    widx_nxt      = widx_r;
    fin_nxt       = fin_r;
    pad_first_nxt = pad_first_r;
    len_ok_nxt    = len_ok_r;
    in_tready     = 1'b0;
    out_tvalid    = 1'b0;
    out_last      = (widx_r == LAST_WORD);

    cmd           = '0;
    cmd.byte_sel  = SEL_IN;
    cmd.len_idx   = fill_r[2:0];
    cmd.widx      = widx_r;
    if (round_r < 7'd20)      cmd.grp = GRP_CH;
    else if (round_r < 7'd40) cmd.grp = GRP_PAR1;
    else if (round_r < 7'd60) cmd.grp = GRP_MAJ;
    else                      cmd.grp = GRP_PAR2;

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_has_byte) begin
            cmd.push      = 1'b1;
            cmd.count_len = 1'b1;
            fill_nxt      = fill_r + 6'd1;
          end
          if (in_end) begin
            fin_nxt       = 1'b1;
            pad_first_nxt = 1'b1;
          end
          if (in_has_byte && fill_r == 6'd63) begin
            state_nxt = ST_LOAD;
          end else if (in_end) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.push = 1'b1;
        if (pad_first_r) begin
          cmd.byte_sel  = SEL_PAD;
          pad_first_nxt = 1'b0;
          len_ok_nxt    = (fill_r < 6'd56);
        end else if (len_ok_r && fill_r >= 6'd56) begin
          cmd.byte_sel = SEL_LEN;
        end else begin
          cmd.byte_sel = SEL_ZERO;
        end
        fill_nxt = fill_r + 6'd1;
        if (fill_r == 6'd63) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        round_nxt = '0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        round_nxt = round_r + 7'd1;
        if (round_r == LAST_ROUND) state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add = 1'b1;
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (pad_first_r) begin
          // message ended exactly on a block boundary
          state_nxt = ST_PAD;
        end else if (len_ok_r) begin
          state_nxt = ST_OUT;
        end else begin
          len_ok_nxt = 1'b1;
          state_nxt  = ST_PAD;
        end
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (widx_r == LAST_WORD) begin
            cmd.rearm     = 1'b1;
            widx_nxt      = '0;
            fin_nxt       = 1'b0;
            pad_first_nxt = 1'b0;
            len_ok_nxt    = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            widx_nxt = widx_r + 3'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // compressions always start on an empty buffer
  a_fill_round: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> (fill_r == 6'd0))
    else $error("fill count nonzero during rounds");

  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && round_r == LAST_ROUND) |=> (state_r == ST_ADD))
    else $error("round sequence did not end in chain add");

  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_last) |=> (state_r == ST_IDLE && widx_r == 3'd0))
    else $error("block did not re-arm after digest");

  a_widx: assert property (@(posedge clk) disable iff (!rst_n)
    widx_r <= LAST_WORD)
    else $error("digest word index out of range");

  a_out_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (fin_r && len_ok_r && !pad_first_r))
    else $error("digest shown before final block");

endmodule

@@ design/sha1_hash.sv @@
// ----------------------------------------------------------------------------
// sha1_hash
// SHA-1 digest of a byte stream, five digest words per message.
// ----------------------------------------------------------------------------
// A message byte is taken while in_tready is high. When the 64th byte of a
// block arrives the block is compressed (load, 80 rounds at one round per
// cycle through a single round unit, chain add), during which in_tready is
// low. On tlast the padding bytes are shifted in one per cycle up to the end
// of one or two final blocks, each followed by a compression, and the digest
// then comes out as five transfers, H0 first. No new input is taken until the
// fifth digest word has been transferred.
module sha1_hash
  import sha1_pkg::*;
#(
  parameter int LENGTH_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] has_byte
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast   // last_word
);

  dp_cmd_t cmd;

  sha1_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_has_byte (in_tuser),
    .in_end      (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_last    (out_tlast),
    .cmd         (cmd)
  );

  sha1_dp #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_byte     (in_tdata),
    .digest_word (out_tdata)
  );

  assign out_tuser = cmd.widx;

endmodule

@@ verif/tb_sha1_hash.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha1_hash
// Self-checking bench for the SHA-1 byte-stream hash block. Messages are sent
// as byte transfers with random gaps. A behavioral SHA-1 model in the bench
// predicts the five digest words of each message, and every output transfer
// is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_sha1_hash;
  import sha1_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_SHOWN   = 10;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] data_byte
  logic        in_tuser = 1'b0;    // [0] has_byte
  logic        in_tlast = 1'b0;    // end_of_message
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // [31:0] digest_word
  logic [2:0]  out_tuser;          // [2:0] word_index
  logic        out_tlast;          // last_word

  sha1_hash dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state
  logic [31:0] chain_h [5];
  logic [7:0]  msg_blk [64];
  int unsigned blk_fill;
  logic [63:0] msg_bits;
  digest_t     digest_q [$];

  int unsigned n_errors  = 0;
  int unsigned n_items   = 0;
  int unsigned n_msgs    = 0;
  int unsigned n_cycles  = 0;
  bit          src_steady  = 1'b0;
  bit          sink_steady = 1'b0;

  function automatic void sha1_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    for (int j = 0; j < 16; j++)
      w[j] = {msg_blk[4*j], msg_blk[4*j+1], msg_blk[4*j+2], msg_blk[4*j+3]};
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16) begin
        x = w[(r-3) & 15] ^ w[(r-8) & 15] ^ w[(r-14) & 15] ^ w[r & 15];
        w[r & 15] = {x[30:0], x[31]};
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_GRP0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_GRP1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_GRP2;
      end else begin
        f = b ^ c ^ d;
        k = K_GRP3;
      end
      t = {a[26:0], a[31:27]} + f + e + w[r & 15] + k;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c;
    chain_h[3] += d; chain_h[4] += e;
  endfunction

  function automatic void sha1_rearm();
    chain_h  = H_INIT;
    blk_fill = 0;
    msg_bits = '0;
  endfunction

  // Apply one accepted transfer to the model; on end of message queue the digest.
  function automatic void absorb_item(logic [7:0] d, logic has, logic eom);
    if (has) begin
      msg_blk[blk_fill] = d;
      blk_fill++;
      msg_bits += 64'd8;
      if (blk_fill == 64) begin
        sha1_compress();
        blk_fill = 0;
      end
    end
    if (!eom)
      return;
    msg_blk[blk_fill] = PAD_BYTE;
    blk_fill++;
    // length field no longer fits: pad out and spill into a second block
    if (blk_fill > 56) begin
      while (blk_fill < 64) begin
        msg_blk[blk_fill] = 8'h00;
        blk_fill++;
      end
      sha1_compress();
      blk_fill = 0;
    end
    while (blk_fill < 56) begin
      msg_blk[blk_fill] = 8'h00;
      blk_fill++;
    end
    for (int i = 0; i < 8; i++)
      msg_blk[56+i] = msg_bits[63-8*i -: 8];
    sha1_compress();
    for (int i = 0; i < 5; i++)
      digest_q.push_back('{word: chain_h[i], idx: 3'(i), last: (i == LAST_WORD)});
    sha1_rearm();
  endfunction

  // Drive one item and hold it until the transfer.
  task automatic send_item(logic [7:0] d, logic has, logic eom);
    int unsigned gap;
    gap = src_steady ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= has;
    in_tlast  <= eom;
    do @(posedge clk); while (in_tready !== 1'b1);
    absorb_item(d, has, eom);
    if (has || eom)
      n_items++;
    if (eom)
      n_msgs++;
  endtask

  task automatic send_message(int unsigned len, bit end_on_byte, int unsigned noise_pct);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte || len == 0)
      send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // Sink: random stall before each result
  always begin : digest_sink
    int unsigned stall;
    stall = sink_steady ? 0 : $urandom_range(0, 8);
    if (stall != 0) begin
      out_tready <= 1'b0;
      repeat (stall) @(posedge clk);
    end
    out_tready <= 1'b1;
    do @(posedge clk); while (out_tvalid !== 1'b1 || !rst_n);
  end

  always @(posedge clk) begin : digest_check
    digest_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (digest_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_SHOWN)
          $display("%0t: unexpected digest transfer word=%h idx=%0d last=%b",
                   $realtime, out_tdata, out_tuser, out_tlast);
      end else begin
        want = digest_q.pop_front();
        if (out_tdata !== want.word || out_tuser !== want.idx || out_tlast !== want.last) begin
          n_errors++;
          if (n_errors <= MAX_SHOWN)
            $display("%0t: digest mismatch exp word=%h idx=%0d last=%b got word=%h idx=%0d last=%b",
                     $realtime, want.word, want.idx, want.last,
                     out_tdata, out_tuser, out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("** sha1_hash: FAILED **");
      $finish;
    end
  end

  // ---- tests ----

  task automatic test_empty_message();
    send_item(8'hA5, 1'b0, 1'b1);
  endtask

  task automatic test_abc();
    // byte and end in the same transfer
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
  endtask

  task automatic test_empty_items();
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h3C, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hAA, 1'b1, 1'b0);
    send_item(8'h55, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
  endtask

  task automatic test_back_to_back();
    // re-arm between messages with no gaps anywhere
    src_steady  = 1'b1;
    sink_steady = 1'b1;
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  task automatic test_random_messages();
    int unsigned edge_len [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
    int unsigned len;
    while (n_items < 120) begin
      if ($urandom_range(0, 3) == 0)
        len = edge_len[$urandom_range(0, 7)];
      else
        len = $urandom_range(0, 20);
      src_steady  = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      send_message(len, 1'($urandom_range(0, 1)), 8);
    end
  endtask

  initial begin
    sha1_rearm();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_message();
    test_abc();
    test_empty_items();
    test_back_to_back();
    test_random_messages();
    in_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (n_errors == 0)
      $display("** sha1_hash: PASSED **");
    else
      $display("** sha1_hash: FAILED **");
    $finish;
  end

endmodule
